@@ hw/rtl/rdm_pkg.sv @@
package rdm_pkg;

  localparam int COLOR_COUNT = 24;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 15;

  localparam logic [1:0] OP_PASS    = 2'd0;
  localparam logic [1:0] OP_TABLE   = 2'd1;
  localparam logic [1:0] OP_RESTORE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_RED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_GREEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEUTRAL_BLUE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_DELAY     = 3'd5;

  // one pass on its way from the control stage to the duty stage
  typedef struct packed {
    logic       restore;
    logic       written;
    logic       in_range;
    logic [7:0] weight_r;
    logic [7:0] weight_g;
    logic [7:0] weight_b;
    logic       power_down;
    logic [5:0] save_level;
    logic [4:0] save_color;
    logic       save_white;
  } pass_t;

  // color wheel, {red, green, blue}
  function automatic logic [23:0] wheel(input logic [4:0] ci);
    logic [23:0] w;
    case (ci)
      5'd0:    w = {8'd255, 8'd0,   8'd0};
      5'd1:    w = {8'd223, 8'd32,  8'd0};
      5'd2:    w = {8'd191, 8'd64,  8'd0};
      5'd3:    w = {8'd159, 8'd96,  8'd0};
      5'd4:    w = {8'd128, 8'd128, 8'd0};
      5'd5:    w = {8'd96,  8'd159, 8'd0};
      5'd6:    w = {8'd64,  8'd191, 8'd0};
      5'd7:    w = {8'd32,  8'd223, 8'd0};
      5'd8:    w = {8'd0,   8'd255, 8'd0};
      5'd9:    w = {8'd0,   8'd223, 8'd32};
      5'd10:   w = {8'd0,   8'd191, 8'd64};
      5'd11:   w = {8'd0,   8'd159, 8'd96};
      5'd12:   w = {8'd0,   8'd128, 8'd128};
      5'd13:   w = {8'd0,   8'd96,  8'd159};
      5'd14:   w = {8'd0,   8'd64,  8'd191};
      5'd15:   w = {8'd0,   8'd32,  8'd223};
      5'd16:   w = {8'd0,   8'd0,   8'd255};
      5'd17:   w = {8'd32,  8'd0,   8'd223};
      5'd18:   w = {8'd64,  8'd0,   8'd191};
      5'd19:   w = {8'd96,  8'd0,   8'd159};
      5'd20:   w = {8'd128, 8'd0,   8'd128};
      5'd21:   w = {8'd159, 8'd0,   8'd96};
      5'd22:   w = {8'd191, 8'd0,   8'd64};
      5'd23:   w = {8'd223, 8'd0,   8'd32};
      default: w = {8'd255, 8'd0,   8'd0};
    endcase
    return w;
  endfunction

endpackage

@@ hw/rtl/rdm_level_ram.sv @@
module rdm_level_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [15:0]   wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [15:0]   rd_data
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/rdm_pass_ctrl.sv @@
module rdm_pass_ctrl
  import rdm_pkg::*;
#(
  parameter int LEVEL_COUNT = 64,
  parameter int AW          = 6
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  accept,
  input  logic [1:0]            opcode,
  input  logic signed [1:0]     bright_step,
  input  logic                  bright_press,
  input  logic signed [1:0]     color_step,
  input  logic                  color_press,
  input  logic [5:0]            entry_index,
  input  logic [15:0]           entry_value,
  input  logic [7:0]            saved_level,
  input  logic [7:0]            saved_color,
  input  logic [7:0]            saved_white,
  output logic                  tbl_wr_en,
  output logic [AW-1:0]         tbl_wr_addr,
  output logic [15:0]           tbl_wr_data,
  output logic                  tbl_rd_en,
  output logic [AW-1:0]         tbl_rd_addr,
  output logic                  pass_valid,
  output pass_t                 pass
);

  logic [5:0]  level_min, level_max;
  logic [7:0]  neutral_red, neutral_green, neutral_blue;
  logic [14:0] off_delay;

  logic [5:0]  bright_level, bright_level_next;
  logic [4:0]  color_index, color_index_next;
  logic        white_mode, white_mode_next;
  logic        off_mode, off_mode_next;
  logic        refresh_pending, refresh_pending_next;
  logic [14:0] off_counter, off_counter_next;
  logic [23:0] wheel_w;

  always_comb begin
    bright_level_next    = bright_level;
    color_index_next     = color_index;
    white_mode_next      = white_mode;
    off_mode_next        = off_mode;
    refresh_pending_next = refresh_pending;
    off_counter_next     = off_counter;
    pass                 = '0;
    wheel_w              = '0;
    case (opcode)
      OP_PASS: begin
        if (bright_step == 2'sd1) begin
          if (bright_level < level_max && !off_mode) begin
            bright_level_next    = bright_level + 6'd1;
            refresh_pending_next = 1'b1;
          end
        end else if (bright_step[1]) begin
          if (bright_level > level_min && !off_mode) begin
            bright_level_next    = bright_level - 6'd1;
            refresh_pending_next = 1'b1;
          end
        end
        if (bright_press) begin
          off_mode_next        = !off_mode;
          refresh_pending_next = 1'b1;
        end
        if (color_step == 2'sd1) begin
          if (!white_mode && !off_mode_next) begin
            color_index_next = (color_index >= 5'(COLOR_COUNT - 1)) ? 5'd0
                                                                   : color_index + 5'd1;
            refresh_pending_next = 1'b1;
          end
        end else if (color_step[1]) begin
          if (!white_mode && !off_mode_next) begin
            color_index_next = (color_index == 5'd0 || color_index >= 5'(COLOR_COUNT))
                               ? 5'(COLOR_COUNT - 1) : color_index - 5'd1;
            refresh_pending_next = 1'b1;
          end
        end
        if (color_press && !off_mode_next) begin
          white_mode_next      = !white_mode;
          refresh_pending_next = 1'b1;
        end
        wheel_w = wheel(color_index_next);
        pass.written = refresh_pending_next;
        pass.in_range = ({26'd0, bright_level_next} < LEVEL_COUNT);
        if (off_mode_next) begin
          pass.weight_r = '0;
          pass.weight_g = '0;
          pass.weight_b = '0;
        end else if (white_mode_next) begin
          pass.weight_r = neutral_red;
          pass.weight_g = neutral_green;
          pass.weight_b = neutral_blue;
        end else begin
          pass.weight_r = wheel_w[23:16];
          pass.weight_g = wheel_w[15:8];
          pass.weight_b = wheel_w[7:0];
        end
        refresh_pending_next = 1'b0;
        if (off_mode_next) begin
          off_counter_next = off_counter + 15'd1;
          pass.power_down  = (off_counter_next == off_delay);
        end else begin
          off_counter_next = '0;
        end
        pass.save_level = bright_level_next;
        pass.save_color = color_index_next;
        pass.save_white = white_mode_next;
      end
      OP_RESTORE: begin
        off_mode_next        = 1'b0;
        off_counter_next     = '0;
        white_mode_next      = (saved_white != 8'd0);
        bright_level_next    = (saved_level < {2'b00, level_min} ||
                                saved_level > {2'b00, level_max}) ? level_min
                                                                   : saved_level[5:0];
        color_index_next     = (saved_color >= 8'(COLOR_COUNT)) ? 5'd0 : saved_color[4:0];
        refresh_pending_next = 1'b1;
        pass.restore         = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign pass_valid  = accept && (opcode == OP_PASS || opcode == OP_RESTORE);
  assign tbl_rd_en   = accept && (opcode == OP_PASS);
  assign tbl_rd_addr = AW'(bright_level_next);
  assign tbl_wr_en   = accept && (opcode == OP_TABLE) && ({26'd0, entry_index} < LEVEL_COUNT);
  assign tbl_wr_addr = AW'(entry_index);
  assign tbl_wr_data = entry_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_min       <= 6'd0;
      level_max       <= 6'd63;
      neutral_red     <= 8'd255;
      neutral_green   <= 8'd255;
      neutral_blue    <= 8'd255;
      off_delay       <= 15'd5000;
      bright_level    <= '0;
      color_index     <= '0;
      white_mode      <= 1'b1;
      off_mode        <= 1'b0;
      refresh_pending <= 1'b1;
      off_counter     <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_LEVEL_MIN:     level_min     <= cfg_data[5:0];
          REG_LEVEL_MAX:     level_max     <= cfg_data[5:0];
          REG_NEUTRAL_RED:   neutral_red   <= cfg_data[7:0];
          REG_NEUTRAL_GREEN: neutral_green <= cfg_data[7:0];
          REG_NEUTRAL_BLUE:  neutral_blue  <= cfg_data[7:0];
          REG_OFF_DELAY:     off_delay     <= cfg_data[14:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        bright_level    <= bright_level_next;
        color_index     <= color_index_next;
        white_mode      <= white_mode_next;
        off_mode        <= off_mode_next;
        refresh_pending <= refresh_pending_next;
        off_counter     <= off_counter_next;
      end
    end
  end

endmodule

@@ hw/rtl/rdm_duty_stage.sv @@
module rdm_duty_stage
  import rdm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        pass_valid,
  input  pass_t       pass,
  input  logic [15:0] tbl_data,
  output logic        free,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata
);

  logic        s1_valid;
  pass_t       s1;
  logic        s1_go;
  logic [15:0] base;
  logic [23:0] prod_r, prod_g, prod_b;
  logic [15:0] duty_hold [3];

  assign s1_go = s1_valid && (s1.restore || !m_tvalid || m_tready);
  assign free  = !s1_valid || s1_go;

  assign base   = s1.in_range ? tbl_data : 16'd0;
  assign prod_r = base * s1.weight_r;
  assign prod_g = base * s1.weight_g;
  assign prod_b = base * s1.weight_b;

  always_ff @(posedge clk) begin
    if (pass_valid) begin
      s1 <= pass;
    end
    if (s1_go && !s1.restore) begin
      if (s1.written) begin
        m_tdata[15:0]  <= prod_r[23:8];
        m_tdata[31:16] <= prod_g[23:8];
        m_tdata[47:32] <= prod_b[23:8];
      end else begin
        m_tdata[15:0]  <= duty_hold[0];
        m_tdata[31:16] <= duty_hold[1];
        m_tdata[47:32] <= duty_hold[2];
      end
      m_tdata[48]    <= s1.written;
      m_tdata[49]    <= s1.power_down;
      m_tdata[55:50] <= s1.save_level;
      m_tdata[60:56] <= s1.save_color;
      m_tdata[61]    <= s1.save_white;
      m_tdata[63:62] <= 2'b00;
    end
    if (rst) begin
      s1_valid     <= 1'b0;
      m_tvalid     <= 1'b0;
      duty_hold[0] <= '0;
      duty_hold[1] <= '0;
      duty_hold[2] <= '0;
    end else begin
      if (s1_go) begin
        if (s1.restore) begin
          duty_hold[0] <= '0;
          duty_hold[1] <= '0;
          duty_hold[2] <= '0;
        end else if (s1.written) begin
          duty_hold[0] <= prod_r[23:8];
          duty_hold[1] <= prod_g[23:8];
          duty_hold[2] <= prod_b[23:8];
        end
      end
      if (pass_valid) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go && !s1.restore) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/rgb_dimmer_mode_controller_core.sv @@
// channel   dir  handshake                  payload
// s_*       in   s_tvalid / s_tready        s_tdata pass fields, s_tuser opcode
// m_*       out  m_tvalid / m_tready        m_tdata duties and save values
// cfg_*     in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// One item per cycle sustained while the output is not stalled; the level table
// read and the pass fields are registered when an item is taken, and the duty
// product is then loaded into the output reg once the output can take it.
// Table writes and restores give no result. The level table has no reset.
// Synchronous reset sets mode state and config to defaults, clears held duties.
// A stalled output holds a control pass in the duty stage; input stalls only then.
module rgb_dimmer_mode_controller_core
  import rdm_pkg::*;
#(
  parameter int LEVEL_COUNT = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [1:0] bright_step, [2] bright_press, [4:3] color_step, [5] color_press,
  // [11:6] entry_index, [27:12] entry_value, [35:28] saved_level,
  // [43:36] saved_color, [51:44] saved_white, [55:52] zero
  input  logic [55:0]           s_tdata,
  // [1:0] opcode
  input  logic [1:0]            s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [15:0] red_duty, [31:16] green_duty, [47:32] blue_duty, [48] duty_written,
  // [49] power_down, [55:50] save_level, [60:56] save_color, [61] save_white,
  // [63:62] zero
  output logic [63:0]           m_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(LEVEL_COUNT);

  logic          accept;
  logic          tbl_wr_en, tbl_rd_en;
  logic [AW-1:0] tbl_wr_addr, tbl_rd_addr;
  logic [15:0]   tbl_wr_data, tbl_rd_data;
  logic          pass_valid;
  pass_t         pass;
  logic          free;

  assign cfg_ready = 1'b1;
  assign s_tready  = free;
  assign accept    = s_tvalid && free;

  rdm_pass_ctrl #(
    .LEVEL_COUNT(LEVEL_COUNT),
    .AW         (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .opcode      (s_tuser),
    .bright_step (s_tdata[1:0]),
    .bright_press(s_tdata[2]),
    .color_step  (s_tdata[4:3]),
    .color_press (s_tdata[5]),
    .entry_index (s_tdata[11:6]),
    .entry_value (s_tdata[27:12]),
    .saved_level (s_tdata[35:28]),
    .saved_color (s_tdata[43:36]),
    .saved_white (s_tdata[51:44]),
    .tbl_wr_en   (tbl_wr_en),
    .tbl_wr_addr (tbl_wr_addr),
    .tbl_wr_data (tbl_wr_data),
    .tbl_rd_en   (tbl_rd_en),
    .tbl_rd_addr (tbl_rd_addr),
    .pass_valid  (pass_valid),
    .pass        (pass)
  );

  rdm_level_ram #(
    .DEPTH(LEVEL_COUNT),
    .AW   (AW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (tbl_wr_en),
    .wr_addr(tbl_wr_addr),
    .wr_data(tbl_wr_data),
    .rd_en  (tbl_rd_en),
    .rd_addr(tbl_rd_addr),
    .rd_data(tbl_rd_data)
  );

  rdm_duty_stage u_duty (
    .clk       (clk),
    .rst       (rst),
    .pass_valid(pass_valid),
    .pass      (pass),
    .tbl_data  (tbl_rd_data),
    .free      (free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

@@ dv/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rdm_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 60;
  localparam int LONG_HOLD       = 300;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  localparam logic [1:0] STEP_NONE     = 2'b00;
  localparam logic [1:0] STEP_UP       = 2'b01;
  localparam logic [1:0] STEP_DOWN_TWO = 2'b10;
  localparam logic [1:0] STEP_DOWN     = 2'b11;

  // {red, green, blue} per wheel position, position 0 in the low bits
  localparam logic [24*24-1:0] HUE_WEIGHTS = {
    24'hDF0020, 24'hBF0040, 24'h9F0060, 24'h800080, 24'h60009F, 24'h4000BF,
    24'h2000DF, 24'h0000FF, 24'h0020DF, 24'h0040BF, 24'h00609F, 24'h008080,
    24'h009F60, 24'h00BF40, 24'h00DF20, 24'h00FF00, 24'h20DF00, 24'h40BF00,
    24'h609F00, 24'h808000, 24'h9F6000, 24'hBF4000, 24'hDF2000, 24'hFF0000
  };

  typedef struct packed {
    logic [1:0]  opcode;
    logic [1:0]  bright_step;
    logic        bright_press;
    logic [1:0]  color_step;
    logic        color_press;
    logic [5:0]  entry_index;
    logic [15:0] entry_value;
    logic [7:0]  saved_level;
    logic [7:0]  saved_color;
    logic [7:0]  saved_white;
  } pass_item_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        written;
    logic        power_down;
    logic [5:0]  level;
    logic [4:0]  color;
    logic        white;
  } duty_report_t;

  typedef struct packed {
    pass_item_t   item;
    logic         typed;
    duty_report_t rep;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [55:0]           s_tdata;
  logic [1:0]            s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [63:0]           m_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // predictor state
  logic [5:0]  cfg_lvl_lo, cfg_lvl_hi;
  logic [7:0]  cfg_white_r, cfg_white_g, cfg_white_b;
  logic [14:0] cfg_off_passes;
  logic [5:0]  st_level;
  logic [4:0]  st_color;
  logic        st_white, st_off, st_dirty;
  logic [14:0] st_off_count;
  logic [15:0] st_duty [3];
  logic [15:0] lut [64];

  duty_report_t expected_reports[$];
  int           mismatches = 0;
  bit           idling = 1'b1;
  bit           stall_sink = 1'b0;

  rgb_dimmer_mode_controller_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic pass_item_t pass_fields(
    logic [1:0] op, logic [1:0] bs, logic bp, logic [1:0] cs, logic cp,
    logic [5:0] ei, logic [15:0] ev, logic [7:0] sl, logic [7:0] sc, logic [7:0] sw);
    pass_item_t it;
    it.opcode       = op;
    it.bright_step  = bs;
    it.bright_press = bp;
    it.color_step   = cs;
    it.color_press  = cp;
    it.entry_index  = ei;
    it.entry_value  = ev;
    it.saved_level  = sl;
    it.saved_color  = sc;
    it.saved_white  = sw;
    return it;
  endfunction

  function automatic duty_report_t report(
    logic [15:0] r, logic [15:0] g, logic [15:0] b, logic wr, logic pd,
    logic [5:0] lvl, logic [4:0] col, logic wh);
    duty_report_t rep;
    rep.red        = r;
    rep.green      = g;
    rep.blue       = b;
    rep.written    = wr;
    rep.power_down = pd;
    rep.level      = lvl;
    rep.color      = col;
    rep.white      = wh;
    return rep;
  endfunction

  function automatic dir_row_t dir_row(pass_item_t it, logic typed, duty_report_t rep);
    dir_row_t row;
    row.item  = it;
    row.typed = typed;
    row.rep   = rep;
    return row;
  endfunction

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_LEVEL_MIN:     cfg_lvl_lo = data[5:0];
      REG_LEVEL_MAX:     cfg_lvl_hi = data[5:0];
      REG_NEUTRAL_RED:   cfg_white_r = data[7:0];
      REG_NEUTRAL_GREEN: cfg_white_g = data[7:0];
      REG_NEUTRAL_BLUE:  cfg_white_b = data[7:0];
      REG_OFF_DELAY:     cfg_off_passes = data[14:0];
      default: ;
    endcase
  endtask

  task automatic advance_dimmer(input pass_item_t it, output logic produced,
                                output duty_report_t rep);
    logic [23:0] weights;
    logic [23:0] prod;
    logic        fresh;
    produced = 1'b0;
    rep = '0;
    fresh = 1'b0;
    case (it.opcode)
      OP_TABLE: lut[it.entry_index] = it.entry_value;
      OP_RESTORE: begin
        st_off = 1'b0;
        st_off_count = '0;
        st_white = (it.saved_white > 8'd1) ? 1'b1 : it.saved_white[0];
        st_level = (it.saved_level < {2'b00, cfg_lvl_lo} || it.saved_level > {2'b00, cfg_lvl_hi})
                   ? cfg_lvl_lo : it.saved_level[5:0];
        st_color = (it.saved_color >= COLOR_COUNT) ? 5'd0 : it.saved_color[4:0];
        st_dirty = 1'b1;
        for (int c = 0; c < 3; c++) st_duty[c] = '0;
      end
      OP_PASS: begin
        if (it.bright_step == STEP_UP) begin
          if (st_level < cfg_lvl_hi && !st_off) begin
            st_level = st_level + 6'd1;
            st_dirty = 1'b1;
          end
        end else if (it.bright_step[1]) begin
          if (st_level > cfg_lvl_lo && !st_off) begin
            st_level = st_level - 6'd1;
            st_dirty = 1'b1;
          end
        end
        if (it.bright_press) begin
          st_off = ~st_off;
          st_dirty = 1'b1;
        end
        if (it.color_step == STEP_UP) begin
          if (!st_white && !st_off) begin
            st_color = (st_color == COLOR_COUNT - 1) ? 5'd0 : st_color + 5'd1;
            st_dirty = 1'b1;
          end
        end else if (it.color_step[1]) begin
          if (!st_white && !st_off) begin
            st_color = (st_color == 5'd0) ? 5'(COLOR_COUNT - 1) : st_color - 5'd1;
            st_dirty = 1'b1;
          end
        end
        if (it.color_press && !st_off) begin
          st_white = ~st_white;
          st_dirty = 1'b1;
        end
        if (st_dirty) begin
          weights = st_white ? {cfg_white_r, cfg_white_g, cfg_white_b}
                             : HUE_WEIGHTS[st_color*24 +: 24];
          for (int c = 0; c < 3; c++) begin
            prod = st_off ? 24'd0 : lut[st_level] * weights[(2-c)*8 +: 8];
            st_duty[c] = prod[23:8];
          end
          st_dirty = 1'b0;
          fresh = 1'b1;
        end
        if (st_off) st_off_count = st_off_count + 15'd1;
        else st_off_count = '0;
        produced = 1'b1;
        rep = report(st_duty[0], st_duty[1], st_duty[2], fresh,
                     st_off && (st_off_count == cfg_off_passes),
                     st_level, st_color, st_white);
      end
      default: ;
    endcase
  endtask

  task automatic send_pass(input pass_item_t it, input logic typed,
                           input duty_report_t typed_rep);
    logic         produced;
    duty_report_t rep;
    if (idling && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= it.opcode;
    s_tdata  <= {4'b0000, it.saved_white, it.saved_color, it.saved_level, it.entry_value,
                 it.entry_index, it.color_press, it.color_step, it.bright_press,
                 it.bright_step};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    advance_dimmer(it, produced, rep);
    if (produced) expected_reports.push_back(typed ? typed_rep : rep);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    apply_reg(idx, data);
  endtask

  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [15:0] want, input logic [15:0] got);
    if (got !== want) begin
      $error("%s expected %0d actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // result side: checker plus ready pattern
  initial begin
    int           burst;
    int           hold_left;
    duty_report_t want;
    duty_report_t got;
    burst = 0;
    hold_left = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid === 1'b1 && m_tready) begin
        got = report(m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[48],
                     m_tdata[49], m_tdata[55:50], m_tdata[60:56], m_tdata[61]);
        if (expected_reports.size() == 0) begin
          $error("duty report arrived with none pending");
          mismatches++;
        end else begin
          want = expected_reports.pop_front();
          check_field("red_duty", want.red, got.red);
          check_field("green_duty", want.green, got.green);
          check_field("blue_duty", want.blue, got.blue);
          check_field("duty_written", 16'(want.written), 16'(got.written));
          check_field("power_down", 16'(want.power_down), 16'(got.power_down));
          check_field("save_level", 16'(want.level), 16'(got.level));
          check_field("save_color", 16'(want.color), 16'(got.color));
          check_field("save_white", 16'(want.white), 16'(got.white));
        end
      end
      if (stall_sink) begin
        stall_sink = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (burst > 0) begin
        burst--;
        m_tready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 8) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    dir_row_t    rows[$];
    pass_item_t  it;
    logic [5:0]  lo, hi, t;
    logic [14:0] junk;
    int          pick;

    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;

    cfg_lvl_lo = 6'd0;
    cfg_lvl_hi = 6'd63;
    cfg_white_r = 8'd255;
    cfg_white_g = 8'd255;
    cfg_white_b = 8'd255;
    cfg_off_passes = 15'd5000;
    st_level = '0;
    st_color = '0;
    st_white = 1'b1;
    st_off = 1'b0;
    st_dirty = 1'b1;
    st_off_count = '0;
    for (int c = 0; c < 3; c++) st_duty[c] = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill the level table so that no read ever hits an unwritten entry
    for (int i = 0; i < 64; i++)
      send_pass(pass_fields(OP_TABLE, STEP_NONE, 1'b0, STEP_NONE, 1'b0, 6'(i),
                            (i == 0) ? 16'h0100 : (i == 63) ? 16'hFFFF : 16'($urandom),
                            8'd0, 8'd0, 8'd0), 1'b0, '0);

    rows.push_back(dir_row(pass_fields(OP_PASS, STEP_NONE, 0, STEP_NONE, 0, 0, 0, 0, 0, 0),
                           1'b1, report(255, 255, 255, 1, 0, 0, 0, 1)));
    rows.push_back(dir_row(pass_fields(OP_PASS, STEP_NONE, 0, STEP_NONE, 0, 0, 0, 0, 0, 0),
                           1'b1, report(255, 255, 255, 0, 0, 0, 0, 1)));
    rows.push_back(dir_row(pass_fields(OP_PASS, STEP_DOWN, 0, STEP_NONE, 0, 0, 0, 0, 0, 0),
                           1'b1, report(255, 255, 255, 0, 0, 0, 0, 1)));
    rows.push_back(dir_row(pass_fields(OP_PASS, STEP_DOWN_TWO, 0, STEP_NONE, 0, 0, 0, 0, 0, 0),
                           1'b1, report(255, 255, 255, 0, 0, 0, 0, 1)));
    rows.push_back(dir_row(pass_fields(OP_PASS, STEP_UP, 0, STEP_NONE, 0, 0, 0, 0, 0, 0),
                           1'b0, '0));
    rows.push_back(dir_row(pass_fields(OP_RESTORE, STEP_NONE, 0, STEP_NONE, 0, 0, 0, 63, 23, 0),
                           1'b0, '0));
    rows.push_back(dir_row(pass_fields(OP_PASS, STEP_NONE, 0, STEP_NONE, 0, 0, 0, 0, 0, 0),
                           1'b0, '0));
    rows.push_back(dir_row(pass_fields(OP_PASS, STEP_UP, 0, STEP_NONE, 0, 0, 0, 0, 0, 0),
                           1'b0, '0));
    rows.push_back(dir_row(pass_fields(OP_PASS, STEP_NONE, 0, STEP_UP, 0, 0, 0, 0, 0, 0),
                           1'b0, '0));
    rows.push_back(dir_row(pass_fields(OP_PASS, STEP_NONE, 0, STEP_DOWN, 0, 0, 0, 0, 0, 0),
                           1'b0, '0));
    rows.push_back(dir_row(pass_fields(OP_PASS, STEP_NONE, 0, STEP_DOWN_TWO, 0, 0, 0, 0, 0, 0),
                           1'b0, '0));
    rows.push_back(dir_row(pass_fields(OP_PASS, STEP_NONE, 0, STEP_NONE, 1, 0, 0, 0, 0, 0),
                           1'b0, '0));
    rows.push_back(dir_row(pass_fields(OP_PASS, STEP_NONE, 0, STEP_UP, 0, 0, 0, 0, 0, 0),
                           1'b0, '0));
    rows.push_back(dir_row(pass_fields(OP_PASS, STEP_NONE, 1, STEP_NONE, 0, 0, 0, 0, 0, 0),
                           1'b1, report(0, 0, 0, 1, 0, 63, 22, 1)));
    rows.push_back(dir_row(pass_fields(OP_PASS, STEP_UP, 0, STEP_UP, 1, 0, 0, 0, 0, 0),
                           1'b1, report(0, 0, 0, 0, 0, 63, 22, 1)));
    rows.push_back(dir_row(pass_fields(OP_PASS, STEP_NONE, 1, STEP_NONE, 0, 0, 0, 0, 0, 0),
                           1'b0, '0));
    rows.push_back(dir_row(pass_fields(OP_RESTORE, STEP_NONE, 0, STEP_NONE, 0, 0, 0,
                                       255, 255, 255), 1'b0, '0));
    rows.push_back(dir_row(pass_fields(OP_RESTORE, STEP_NONE, 0, STEP_NONE, 0, 0, 0, 64, 24, 2),
                           1'b0, '0));
    rows.push_back(dir_row(pass_fields(OP_PASS, STEP_NONE, 0, STEP_NONE, 0, 0, 0, 0, 0, 0),
                           1'b1, report(255, 255, 255, 1, 0, 0, 0, 1)));
    rows.push_back(dir_row(pass_fields(OP_TABLE, STEP_NONE, 0, STEP_NONE, 0, 0, 16'hFFFF,
                                       0, 0, 0), 1'b0, '0));
    rows.push_back(dir_row(pass_fields(OP_TABLE, STEP_NONE, 0, STEP_NONE, 0, 63, 16'h0000,
                                       0, 0, 0), 1'b0, '0));
    rows.push_back(dir_row(pass_fields(OP_PASS, STEP_DOWN, 1, STEP_DOWN, 1, 63, 16'hFFFF,
                                       255, 255, 255), 1'b0, '0));
    rows.push_back(dir_row(pass_fields(OP_UNUSED, STEP_DOWN, 1, STEP_DOWN, 1, 63, 16'hFFFF,
                                       255, 255, 255), 1'b0, '0));
    rows.push_back(dir_row(pass_fields(OP_PASS, STEP_NONE, 1, STEP_NONE, 0, 0, 0, 0, 0, 0),
                           1'b0, '0));
    rows.push_back(dir_row(pass_fields(OP_PASS, STEP_UP, 0, STEP_NONE, 0, 0, 0, 0, 0, 0),
                           1'b0, '0));

    foreach (rows[i]) send_pass(rows[i].item, rows[i].typed, rows[i].rep);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_quiet();
      if (ph == 0) begin
        lo = 6'd0;
        hi = 6'd63;
      end else if (ph == 1) begin
        lo = 6'd63;
        hi = 6'd0;
      end else begin
        lo = 6'($urandom_range(0, 63));
        hi = 6'($urandom_range(0, 63));
        if (lo > hi && $urandom_range(0, 3) != 0) begin
          t = lo;
          lo = hi;
          hi = t;
        end
      end
      junk = 15'($urandom);
      write_reg(REG_LEVEL_MIN, {junk[14:6], lo});
      junk = 15'($urandom);
      write_reg(REG_LEVEL_MAX, {junk[14:6], hi});
      junk = 15'($urandom);
      write_reg(REG_NEUTRAL_RED, {junk[14:8], (ph == 0) ? 8'd0 : (ph == 1) ? 8'd255
                                                      : 8'($urandom)});
      junk = 15'($urandom);
      write_reg(REG_NEUTRAL_GREEN, {junk[14:8], (ph == 0) ? 8'd0 : (ph == 1) ? 8'd255
                                                        : 8'($urandom)});
      junk = 15'($urandom);
      write_reg(REG_NEUTRAL_BLUE, {junk[14:8], (ph == 0) ? 8'd0 : (ph == 1) ? 8'd255
                                                       : 8'($urandom)});
      write_reg(REG_OFF_DELAY, (ph == 0) ? 15'd1 : (ph == 1) ? 15'd32767
                                         : 15'($urandom_range(1, 12)));
      write_reg(REG_SPARE, 15'($urandom));
      cfg_valid <= 1'b0;

      idling = (ph != PHASES - 1);
      if (ph == 3) stall_sink = 1'b1;

      repeat (ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 19);
        it.opcode       = (pick < 15) ? OP_PASS : (pick < 17) ? OP_TABLE
                        : (pick < 19) ? OP_RESTORE : OP_UNUSED;
        it.bright_step  = 2'($urandom_range(0, 3));
        it.bright_press = ($urandom_range(0, 7) == 0);
        it.color_step   = 2'($urandom_range(0, 3));
        it.color_press  = ($urandom_range(0, 5) == 0);
        it.entry_index  = 6'($urandom_range(0, 63));
        it.entry_value  = 16'($urandom);
        it.saved_level  = $urandom_range(0, 1) ? 8'($urandom_range(0, 63)) : 8'($urandom);
        it.saved_color  = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 23))
                                                      : 8'($urandom);
        it.saved_white  = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 1))
                                                      : 8'($urandom);
        send_pass(it, 1'b0, '0);
      end
    end

    wait_quiet();
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
